@@ hw/rtl/mfsd_pkg.sv @@
// Shared constants for the mixed fraction subtractor with decimal text output.
// No dependencies; used by the top level, the checker and the testbench.
package mfsd_pkg;

	// default configuration of the top level
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int MAX_BUF_LEN_DEF   = 64;

	// buffer length register
	localparam int         LEN_W       = 7;
	localparam logic [6:0] BUF_LEN_RST = 7'd9;

	// output characters
	localparam int         CHAR_W   = 8;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// decimal radix
	localparam logic [3:0] DEC_BASE = 4'd10;
	localparam int         DIG_W    = 4;

endpackage

@@ hw/rtl/mfsd_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, unsigned operands.
// Depends on nothing beyond its parameters.
module mfsd_mul #(
	parameter int A_W = 32,
	parameter int B_W = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic                 done,
	output logic [A_W+B_W-1:0]   prod
);
	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [P_W-1:0]   mc_q;
	logic [B_W-1:0]   mp_q;
	logic [P_W-1:0]   acc_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= P_W'(a);
			mp_q  <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[P_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ hw/rtl/mfsd_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Caller guarantees dividend < divisor * 2**Q_W. No dependencies.
module mfsd_div #(
	parameter int DVD_W = 48,
	parameter int DVS_W = 32,
	parameter int Q_W   = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [Q_W-1:0]   quo,
	output logic [DVS_W-1:0] rem
);
	localparam int CW    = DVS_W + Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    par_q;
	logic [CW-1:0]    dsr_q;
	logic [Q_W-1:0]   quo_q;
	logic [CW:0]      diff;

	assign diff = {1'b0, par_q} - {1'b0, dsr_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// trial subtract of the aligned divisor, divisor walks right
	always_ff @(posedge clk) begin
		if (start) begin
			par_q <= CW'(dividend);
			dsr_q <= CW'(divisor) << (Q_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (!diff[CW]) par_q <= diff[CW-1:0];
			quo_q <= {quo_q[Q_W-2:0], ~diff[CW]};
			dsr_q <= {1'b0, dsr_q[CW-1:1]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = par_q[DVS_W-1:0];

endmodule

@@ hw/rtl/mixed_fraction_subtract_to_decimal.sv @@
// Top level: operand intake, sequencer, digit store and character output.
// Depends on mfsd_pkg, mfsd_mul and mfsd_div.
//
//  channel   | signals                            | direction | request
//  ----------+------------------------------------+-----------+------------------------
//  operands  | op_valid op_stall whole/num/den    | in        | two mixed numbers
//  buf_len   | wr_en wr_data                      | in        | buffer length write
//  text      | char_valid char_stall out_char ok  | out       | one character, last
//
// One request at a time. The sequencer forms the products, the sum and the division, then
// the integer digits and the length check, and then emits the characters, working out each
// decimal digit by repeated addition as it goes.
// The serial multiplier and the bit-per-cycle dividers do the arithmetic.
// Reset clears the sequencer and the output valid flag; buf_len returns to 9.
// A stalled character holds; operands are taken again once the sequencer is idle.
module mixed_fraction_subtract_to_decimal #(
	parameter int OPERAND_WIDTH = mfsd_pkg::OPERAND_WIDTH_DEF,
	parameter int MAX_BUF_LEN   = mfsd_pkg::MAX_BUF_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              op_valid,
	output logic                              op_stall,
	input  logic signed [OPERAND_WIDTH-1:0]   whole_a,
	input  logic signed [OPERAND_WIDTH-1:0]   num_a,
	input  logic signed [OPERAND_WIDTH-1:0]   den_a,
	input  logic signed [OPERAND_WIDTH-1:0]   whole_b,
	input  logic signed [OPERAND_WIDTH-1:0]   num_b,
	input  logic signed [OPERAND_WIDTH-1:0]   den_b,
	input  logic                              wr_en,
	input  logic [mfsd_pkg::LEN_W-1:0]        wr_data,
	output logic                              char_valid,
	input  logic                              char_stall,
	output logic [mfsd_pkg::CHAR_W-1:0]       out_char,
	output logic                              ok,
	output logic                              last
);
	localparam int W     = OPERAND_WIDTH;
	localparam int LW    = mfsd_pkg::LEN_W;
	localparam int MA_W  = 2 * W;          // multiplicand width
	localparam int MB_W  = W + 1;          // multiplier width
	localparam int P_W   = MA_W + MB_W;    // product width
	localparam int T_W   = P_W + 1;        // signed total numerator
	localparam int DVD_W = 3 * W;          // magnitude of the total numerator
	localparam int MAG_W = W + 1;          // integer magnitude
	localparam int DIG_N = ((W + 1) * 30103) / 100000 + 1;
	localparam int DIX_W = $clog2(DIG_N);
	localparam int DCN_W = $clog2(DIG_N + 1);
	localparam int DG_W  = mfsd_pkg::DIG_W;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_MUL0 = 15'b000000000000010,
		S_MUL1 = 15'b000000000000100,
		S_MUL2 = 15'b000000000001000,
		S_MUL3 = 15'b000000000010000,
		S_ABS  = 15'b000000000100000,
		S_DIV  = 15'b000000001000000,
		S_DEC  = 15'b000000010000000,
		S_CHK  = 15'b000000100000000,
		S_SIGN = 15'b000001000000000,
		S_INT  = 15'b000010000000000,
		S_DOT  = 15'b000100000000000,
		S_FRAC = 15'b001000000000000,
		S_FDIG = 15'b010000000000000,
		S_FAIL = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [LW-1:0] buf_len_q;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] limit;

	// operand registers
	logic [W-1:0]        mnb_q, mda_q, mdb_q;
	logic signed [W:0]   dw_q;
	logic [W:0]          dw_abs;
	logic [W-1:0]        abs_na, abs_nb, abs_da, abs_db;
	logic signed [W:0]   dw_in;
	logic                bad_ops;

	// arithmetic registers
	logic signed [T_W-1:0] diff_q;
	logic signed [T_W-1:0] t_q;
	logic signed [T_W-1:0] t_neg;
	logic signed [T_W-1:0] t_abs;
	logic signed [T_W-1:0] prod_s;
	logic [MA_W-1:0]       nd_q;
	logic [MA_W-1:0]       rem_q;
	logic [MA_W:0]         acc_q;
	logic [MA_W:0]         acc_sum;
	logic [MA_W:0]         acc_red;
	logic [DG_W-1:0]       fd_q;
	logic [DG_W-1:0]       fj_q;
	logic                  neg_q;

	// digit store
	logic [DG_W-1:0]  digs_q [DIG_N];
	logic [DCN_W-1:0] cnt_q;
	logic [DCN_W-1:0] idx_q;
	logic [LW-1:0]    k_q;
	logic [LW-1:0]    need;

	// unit connections
	logic              mul_start, mul_done;
	logic [MA_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic [P_W-1:0]    mul_prod;
	logic              td_start, td_done;
	logic [MAG_W-1:0]  td_quo;
	logic [MA_W-1:0]   td_rem;
	logic              d10_start, d10_done;
	logic [MAG_W-1:0]  d10_in;
	logic [MAG_W-1:0]  d10_quo;
	logic [DG_W-1:0]   d10_rem;

	// output register
	logic                        cv_q;
	logic [mfsd_pkg::CHAR_W-1:0] ch_q;
	logic                        ok_q, last_q;
	logic                        emit, go;
	logic [mfsd_pkg::CHAR_W-1:0] e_char;
	logic                        e_ok, e_last;
	logic                        accept;

	assign accept   = op_valid && (state_q == S_IDLE);
	assign op_stall = (state_q != S_IDLE);

	// operand magnitudes and sign checks
	assign abs_na = num_a[W-1] ? W'(-num_a) : W'(num_a);
	assign abs_nb = num_b[W-1] ? W'(-num_b) : W'(num_b);
	assign abs_da = den_a[W-1] ? W'(-den_a) : W'(den_a);
	assign abs_db = den_b[W-1] ? W'(-den_b) : W'(den_b);
	assign dw_in  = (W+1)'(whole_a) - (W+1)'(whole_b);
	assign dw_abs = dw_q[W] ? (W+1)'(-dw_q) : (W+1)'(dw_q);
	assign bad_ops = ((num_a != '0) && (den_b != '0) && (num_a[W-1] ^ den_b[W-1]))
	              || ((num_b != '0) && (den_a != '0) && (num_b[W-1] ^ den_a[W-1]))
	              || (den_a == '0) || (den_b == '0) || (den_a[W-1] ^ den_b[W-1]);

	// effective buffer length
	assign len_eff = (buf_len_q > LW'(MAX_BUF_LEN)) ? LW'(MAX_BUF_LEN) : buf_len_q;
	assign limit   = len_eff - LW'(1);
	assign need    = LW'(cnt_q) + LW'(neg_q) + ((rem_q != '0) ? LW'(2) : LW'(0));

	// multiplier operand select
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_IDLE: begin
				mul_start = accept && !bad_ops;
				mul_a     = MA_W'(abs_na);
				mul_b     = MB_W'(abs_db);
			end
			S_MUL0: begin
				mul_start = mul_done;
				mul_a     = MA_W'(mnb_q);
				mul_b     = MB_W'(mda_q);
			end
			S_MUL1: begin
				mul_start = mul_done;
				mul_a     = MA_W'(mda_q);
				mul_b     = MB_W'(mdb_q);
			end
			S_MUL2: begin
				mul_start = mul_done;
				mul_a     = mul_prod[MA_W-1:0];
				mul_b     = dw_abs;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mfsd_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	// total numerator and its magnitude
	assign prod_s = T_W'(mul_prod);
	assign t_neg  = -t_q;
	assign t_abs  = t_q[T_W-1] ? t_neg : t_q;
	assign td_start = (state_q == S_ABS);

	mfsd_div #(.DVD_W(DVD_W), .DVS_W(MA_W), .Q_W(MAG_W)) u_tdiv (
		.clk(clk), .arst_n(arst_n), .start(td_start), .dividend(t_abs[DVD_W-1:0]),
		.divisor(nd_q), .done(td_done), .quo(td_quo), .rem(td_rem)
	);

	// integer digits, least significant first
	assign d10_start = ((state_q == S_DIV) && td_done)
	                || ((state_q == S_DEC) && d10_done && (d10_quo != '0));
	assign d10_in    = (state_q == S_DIV) ? td_quo : d10_quo;

	mfsd_div #(.DVD_W(MAG_W), .DVS_W(DG_W), .Q_W(MAG_W)) u_d10 (
		.clk(clk), .arst_n(arst_n), .start(d10_start), .dividend(d10_in),
		.divisor(mfsd_pkg::DEC_BASE), .done(d10_done), .quo(d10_quo), .rem(d10_rem)
	);

	// one repeated-add step of the decimal digit
	assign acc_sum = acc_q + (MA_W+1)'(rem_q);
	assign acc_red = (acc_sum >= (MA_W+1)'(nd_q)) ? acc_sum - (MA_W+1)'(nd_q) : acc_sum;

	// character for the current state
	assign go = !cv_q || !char_stall;
	always_comb begin
		emit   = 1'b0;
		e_char = mfsd_pkg::CH_NUL;
		e_ok   = 1'b1;
		e_last = 1'b0;
		case (state_q)
			S_SIGN: begin
				emit   = 1'b1;
				e_char = mfsd_pkg::CH_MINUS;
			end
			S_INT: begin
				emit   = 1'b1;
				e_char = mfsd_pkg::CH_ZERO
				       + mfsd_pkg::CHAR_W'(digs_q[idx_q[DIX_W-1:0]]);
				e_last = (idx_q == '0) && (rem_q == '0);
			end
			S_DOT: begin
				emit   = 1'b1;
				e_char = mfsd_pkg::CH_POINT;
			end
			S_FDIG: begin
				emit   = 1'b1;
				e_char = mfsd_pkg::CH_ZERO + mfsd_pkg::CHAR_W'(fd_q);
				e_last = (acc_q == '0) || ((k_q + LW'(1)) >= limit);
			end
			S_FAIL: begin
				emit   = 1'b1;
				e_ok   = 1'b0;
				e_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			buf_len_q <= mfsd_pkg::BUF_LEN_RST;
			cv_q      <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			k_q       <= '0;
			fj_q      <= '0;
		end else begin
			if (wr_en) buf_len_q <= wr_data;
			if (emit && go) begin
				cv_q <= 1'b1;
				k_q  <= k_q + LW'(1);
			end else if (!char_stall) begin
				cv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					k_q   <= '0;
					cnt_q <= '0;
					if (accept) state_q <= bad_ops ? S_FAIL : S_MUL0;
				end
				S_MUL0: if (mul_done) state_q <= S_MUL1;
				S_MUL1: if (mul_done) state_q <= S_MUL2;
				S_MUL2: if (mul_done) state_q <= S_MUL3;
				S_MUL3: if (mul_done) state_q <= S_ABS;
				S_ABS:  state_q <= S_DIV;
				S_DIV:  if (td_done) state_q <= S_DEC;
				S_DEC: begin
					if (d10_done) begin
						cnt_q <= cnt_q + DCN_W'(1);
						if (d10_quo == '0) state_q <= S_CHK;
					end
				end
				S_CHK: begin
					idx_q <= cnt_q - DCN_W'(1);
					if ((len_eff < LW'(2)) || (need > limit)) state_q <= S_FAIL;
					else if (neg_q) state_q <= S_SIGN;
					else state_q <= S_INT;
				end
				S_SIGN: if (go) state_q <= S_INT;
				S_INT: begin
					if (go) begin
						idx_q <= idx_q - DCN_W'(1);
						if (idx_q == '0) state_q <= (rem_q != '0) ? S_DOT : S_IDLE;
					end
				end
				S_DOT: begin
					fj_q <= '0;
					if (go) state_q <= S_FRAC;
				end
				S_FRAC: begin
					fj_q <= fj_q + DG_W'(1);
					if (fj_q == mfsd_pkg::DEC_BASE - DG_W'(1)) state_q <= S_FDIG;
				end
				S_FDIG: begin
					fj_q <= '0;
					if (go) state_q <= e_last ? S_IDLE : S_FRAC;
				end
				S_FAIL: if (go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mnb_q <= abs_nb;
			mda_q <= abs_da;
			mdb_q <= abs_db;
			dw_q  <= dw_in;
		end
		if ((state_q == S_MUL0) && mul_done) diff_q <= prod_s;
		if ((state_q == S_MUL1) && mul_done) diff_q <= diff_q - prod_s;
		if ((state_q == S_MUL2) && mul_done) nd_q <= mul_prod[MA_W-1:0];
		if ((state_q == S_MUL3) && mul_done) t_q <= (dw_q[W] ? -prod_s : prod_s) + diff_q;
		if (state_q == S_ABS) neg_q <= t_q[T_W-1];
		if ((state_q == S_DIV) && td_done) rem_q <= td_rem;
		if ((state_q == S_DEC) && d10_done) digs_q[cnt_q[DIX_W-1:0]] <= d10_rem;
		if (state_q == S_DOT) begin
			acc_q <= '0;
			fd_q  <= '0;
		end
		if (state_q == S_FRAC) begin
			acc_q <= acc_red;
			if (acc_sum >= (MA_W+1)'(nd_q)) fd_q <= fd_q + DG_W'(1);
		end
		if ((state_q == S_FDIG) && go) begin
			rem_q <= acc_q[MA_W-1:0];
			acc_q <= '0;
			fd_q  <= '0;
		end
		if (emit && go) begin
			ch_q   <= e_char;
			ok_q   <= e_ok;
			last_q <= e_last;
		end
	end

	assign char_valid = cv_q;
	assign out_char   = ch_q;
	assign ok         = ok_q;
	assign last       = last_q;

endmodule

@@ hw/rtl/mfsd_chk.sv @@
// Port-level checks for the mixed fraction subtractor, bound to its top level.
// Depends on mfsd_pkg and mixed_fraction_subtract_to_decimal.
module mfsd_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        op_valid,
	input logic                        op_stall,
	input logic                        char_valid,
	input logic                        char_stall,
	input logic [mfsd_pkg::CHAR_W-1:0] out_char,
	input logic                        ok,
	input logic                        last
);

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(last))
		else $error("stalled character changed");

	// a failed request is a single NUL marked last
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !ok |-> last && (out_char == mfsd_pkg::CH_NUL))
		else $error("failed request not a single NUL");

	// good characters are never NUL
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && ok |-> (out_char != mfsd_pkg::CH_NUL))
		else $error("NUL on a good request");

	// an accepted request keeps the operand side busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("operands taken twice in a row");

endmodule

bind mixed_fraction_subtract_to_decimal mfsd_chk u_mfsd_chk (.*);

@@ tb/tb.sv @@
// Testbench for mixed_fraction_subtract_to_decimal: directed, length-sweep and random mixed-number pairs.
// Depends on mfsd_pkg and the block's RTL; expected characters come from an in-bench model.
`timescale 1ns / 100ps

module tb;

	localparam int W = mfsd_pkg::OPERAND_WIDTH_DEF;
	localparam int LIMIT_CYCLES = 2000000;

	typedef struct packed {
		logic [mfsd_pkg::CHAR_W-1:0] ch;
		logic                        ok;
		logic                        last;
	} text_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	logic signed [W-1:0] whole_a = '0, num_a = '0, den_a = '0;
	logic signed [W-1:0] whole_b = '0, num_b = '0, den_b = '0;
	logic wr_en = 1'b0;
	logic [mfsd_pkg::LEN_W-1:0] wr_data = '0;
	logic char_valid;
	logic char_stall = 1'b0;
	logic [mfsd_pkg::CHAR_W-1:0] out_char;
	logic ok, last;

	text_t expected_chars[$];
	int    buf_len_cur = mfsd_pkg::BUF_LEN_RST;
	int    err_cnt = 0;
	int    cycle_cnt = 0;
	bit    calm = 1'b0;

	mixed_fraction_subtract_to_decimal uut (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op_stall(op_stall),
		.whole_a(whole_a), .num_a(num_a), .den_a(den_a),
		.whole_b(whole_b), .num_b(num_b), .den_b(den_b),
		.wr_en(wr_en), .wr_data(wr_data), .char_valid(char_valid),
		.char_stall(char_stall), .out_char(out_char), .ok(ok), .last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("tb: errors");
			$finish;
		end
	end

	// random backpressure on the text channel
	always @(posedge clk) begin
		char_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
	end

	// compare each accepted character with the oldest expectation
	always @(posedge clk) begin
		text_t want;
		if (arst_n && char_valid && !char_stall) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character %h", out_char);
				err_cnt++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char exp %h got %h", want.ch, out_char);
					err_cnt++;
				end
				if (ok !== want.ok) begin
					$error("ok exp %b got %b", want.ok, ok);
					err_cnt++;
				end
				if (last !== want.last) begin
					$error("last exp %b got %b", want.last, last);
					err_cnt++;
				end
			end
		end
	end

	function automatic void push_char(logic [7:0] c, logic o, logic l);
		text_t t;
		t.ch = c;
		t.ok = o;
		t.last = l;
		expected_chars.push_back(t);
	endfunction

	// expected text for A - B at the current buffer length
	function automatic void predict_text(longint wa, longint na, longint da,
			longint wb, longint nb, longint db);
		longint n1, n2, dd, q, r, qq, rr, mag, rem, lim, len, acc;
		bit neg;
		logic [7:0] digs[$];
		n1 = na * db;
		n2 = nb * da;
		dd = da * db;
		if (n1 < 0 || n2 < 0 || dd <= 0) begin
			push_char(mfsd_pkg::CH_NUL, 1'b0, 1'b1);
			return;
		end
		r = n1 - n2;
		qq = r / dd;
		rr = r % dd;
		if (rr < 0) begin
			rr += dd;
			qq -= 1;
		end
		q = (wa - wb) + qq;
		neg = 1'b0;
		mag = q;
		rem = rr;
		if (q < 0) begin
			neg = 1'b1;
			if (rr == 0) begin
				mag = -q;
				rem = 0;
			end else begin
				mag = -(q + 1);
				rem = dd - rr;
			end
		end
		len = (buf_len_cur > mfsd_pkg::MAX_BUF_LEN_DEF) ? mfsd_pkg::MAX_BUF_LEN_DEF
			: buf_len_cur;
		if (len < 2) begin
			push_char(mfsd_pkg::CH_NUL, 1'b0, 1'b1);
			return;
		end
		lim = len - 1;
		do begin
			digs.push_front(mfsd_pkg::CH_ZERO + 8'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (digs.size() + (neg ? 1 : 0) + (rem != 0 ? 2 : 0) > lim) begin
			push_char(mfsd_pkg::CH_NUL, 1'b0, 1'b1);
			return;
		end
		if (neg) begin
			digs.push_front(mfsd_pkg::CH_MINUS);
		end
		if (rem != 0) begin
			digs.push_back(mfsd_pkg::CH_POINT);
			while (rem != 0 && digs.size() < lim) begin
				acc = rem * 10;
				digs.push_back(mfsd_pkg::CH_ZERO + 8'(acc / dd));
				rem = acc % dd;
			end
		end
		foreach (digs[i])
			push_char(digs[i], 1'b1, i == digs.size() - 1);
	endfunction

	// send one request, predicting its text
	task automatic send_pair(int wa, int na, int da, int wb, int nb, int db);
		while (!calm && $urandom_range(99) < 20)
			@(posedge clk);
		predict_text(longint'(W'(wa)), longint'(W'(na)), longint'(W'(da)),
			longint'(W'(wb)), longint'(W'(nb)), longint'(W'(db)));
		op_valid <= 1'b1;
		whole_a <= W'(wa);
		num_a <= W'(na);
		den_a <= W'(da);
		whole_b <= W'(wb);
		num_b <= W'(nb);
		den_b <= W'(db);
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		op_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_buf_len(int v);
		drain();
		wr_en <= 1'b1;
		wr_data <= mfsd_pkg::LEN_W'(v);
		@(posedge clk);
		wr_en <= 1'b0;
		buf_len_cur = v;
	endtask

	function automatic int rnd_s16();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	function automatic int rnd_small();
		return int'($urandom_range(40)) - 20;
	endfunction

	// extremes, zero difference, negative below one, invalid operands
	task automatic test_directed();
		send_pair(0, 0, 1, 0, 0, 1);
		send_pair(1, 1, 2, 1, 1, 2);
		send_pair(0, 1, 3, 0, 2, 3);
		send_pair(2, 1, 4, 0, 0, 1);
		send_pair(0, 1, 7, 0, 0, 1);
		send_pair(0, 0, 1, 0, 1, 7);
		send_pair(-3, -1, -2, 0, 1, 3);
		send_pair(0, -1, 2, 0, 0, 1);
		send_pair(0, 1, 0, 0, 0, 1);
		send_pair(0, 0, 1, 0, 1, -2);
		send_pair(32767, 32767, 1, -32768, 0, 1);
		send_pair(-32768, 0, 1, 32767, 32767, 1);
		send_pair(5, -32768, -32768, 2, 32767, 32767);
		send_pair(0, 32767, -32768, 0, -1, 32767);
		send_pair(-1, 1, 32767, 0, 1, -32768);
		send_pair(100, 1, 3, 0, 0, 1);
		send_pair(12345, 0, 1, 0, 0, 1);
	endtask

	task automatic test_buf_len_sweep();
		int lens[6] = '{0, 1, 2, 3, 64, 127};
		foreach (lens[i]) begin
			set_buf_len(lens[i]);
			send_pair(0, 0, 1, 0, 0, 1);
			send_pair(0, 1, 3, 0, 0, 1);
			send_pair(-7, 2, 9, 0, 0, 1);
			send_pair(32767, 32766, 32767, -32768, 1, 32767);
		end
	endtask

	// random operands, about half valid by construction, the rest mostly invalid
	task automatic test_random();
		int lens[5] = '{64, 9, 20, 5, 40};
		foreach (lens[p]) begin
			set_buf_len(lens[p]);
			calm = (p == 2);
			for (int i = 0; i < 28; i++) begin
				case ($urandom_range(3))
					0: send_pair(rnd_s16(), rnd_s16(), rnd_s16(), rnd_s16(), rnd_s16(),
						rnd_s16());
					1: send_pair(rnd_small(), $urandom_range(30), 1 + $urandom_range(30),
						rnd_small(), $urandom_range(30), 1 + $urandom_range(30));
					2: send_pair(rnd_small(), -int'($urandom_range(30)),
						-1 - int'($urandom_range(30)), rnd_s16(), $urandom_range(32767),
						1 + $urandom_range(32766));
					default: send_pair(rnd_s16(), $urandom_range(32767),
						1 + $urandom_range(32766), rnd_s16(), $urandom_range(32767),
						1 + $urandom_range(32766));
				endcase
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_buf_len_sweep();
		test_random();
		drain();
		if (err_cnt == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mfsd_pkg.sv
hw/rtl/mfsd_mul.sv
hw/rtl/mfsd_div.sv
hw/rtl/mixed_fraction_subtract_to_decimal.sv
hw/rtl/mfsd_chk.sv
tb/tb.sv
